// ----- hdl/pfra_pkg.sv -----
package pfra_pkg;

    // fixed field widths
    localparam int PID_W     = 4;
    localparam int SIZE_W    = 32;
    localparam int PS_W      = 17;
    localparam int QUO_W     = SIZE_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam logic [PS_W-1:0] PS_RESET = 17'd4096;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;
    localparam int PID_LSB   = 0;
    localparam int SIZE_LSB  = PID_LSB + PID_W;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clr_run;
        logic cnt_load;
        logic div_start;
        logic grow_start;
        logic grow_run;
        logic shr_run;
        logic pc_wr;
        logic out_load;
    } pfra_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic in_range;
        logic div_done;
        logic want_gt;
        logic want_lt;
        logic grow_done;
        logic shr_done;
        logic out_free;
    } pfra_sts_t;

endpackage

// ----- hdl/pfra_div.sv -----
module pfra_div
    import pfra_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [PS_W-1:0]  divisor,
    output logic [QUO_W-1:0] quotient,
    output logic             done
);

    // restoring divider, one quotient bit per cycle
    logic [QUO_W-1:0]     shq_reg;
    logic [PS_W-1:0]      rem_reg;
    logic [PS_W-1:0]      dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [PS_W:0]        trial;
    logic [PS_W:0]        diff;
    logic                 ge;

    assign trial = {rem_reg, shq_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(QUO_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shq_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            shq_reg <= {shq_reg[QUO_W-2:0], ge};
            rem_reg <= ge ? diff[PS_W-1:0] : trial[PS_W-1:0];
        end
    end

    assign quotient = shq_reg;
    assign done     = done_reg;

endmodule

// ----- hdl/pfra_datapath.sv -----
module pfra_datapath
    import pfra_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int NUM_PROCS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [PS_W-1:0]   cfg_wdata,
    input  logic [PID_W-1:0]  proc_id,
    input  logic [SIZE_W-1:0] req_size,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic              status,
    input  pfra_cmd_t         cmd,
    output pfra_sts_t         sts
);

    localparam int FW   = $clog2(NUM_FRAMES);
    localparam int CW   = $clog2(NUM_FRAMES + 1);
    localparam int PIW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int TDEP = NUM_PROCS * NUM_FRAMES;
    localparam int TAW  = $clog2(TDEP);
    localparam int CLRN = (NUM_FRAMES > NUM_PROCS) ? NUM_FRAMES : NUM_PROCS;
    localparam int CLW  = $clog2(CLRN + 1);

    // storage
    logic          map_mem [NUM_FRAMES];
    logic [CW-1:0] pc_mem  [NUM_PROCS];
    logic [FW-1:0] tbl_mem [TDEP];

    logic          map_rdata_reg;
    logic [CW-1:0] pc_rdata_reg;
    logic [FW-1:0] tbl_rdata_reg;

    // request context
    logic [PS_W-1:0]   pg_size_reg;
    logic [PIW-1:0]    proc_reg;
    logic              in_range_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [TAW-1:0]    base_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     scan_reg;
    logic [CW-1:0]     scan_next;
    logic              rd_pend_reg;
    logic              rd_pend_next;
    logic [FW-1:0]     rd_addr_reg;
    logic              shr_pend_reg;
    logic              shr_pend_next;
    logic [CLW-1:0]    clr_reg;
    logic              m_valid_reg;
    logic              status_reg;

    logic [7:0]        proc_ext;
    logic [PIW-1:0]    pidx_in;
    logic [PS_W-1:0]   ps_eff;
    logic [QUO_W-1:0]  dividend;
    logic [QUO_W-1:0]  want;
    logic              div_done;
    logic [QUO_W-1:0]  count_ext;
    logic              want_eq;
    logic              cnt_full;
    logic              scan_exh;
    logic              grow_take;
    logic              shr_issue;
    logic [CW-1:0]     count_dec;

    logic              map_we;
    logic [FW-1:0]     map_waddr;
    logic              map_wdata;
    logic              pc_we;
    logic [PIW-1:0]    pc_waddr;
    logic [CW-1:0]     pc_wdata;
    logic [TAW-1:0]    tbl_waddr;
    logic [TAW-1:0]    tbl_raddr;

    assign proc_ext = {{(8 - PID_W){1'b0}}, proc_id};
    assign pidx_in  = proc_ext[PIW-1:0];
    assign ps_eff   = (pg_size_reg == '0) ? PS_W'(1) : pg_size_reg;
    assign dividend = QUO_W'(size_reg) + QUO_W'(ps_eff) - QUO_W'(1);

    pfra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (ps_eff),
        .quotient (want),
        .done     (div_done)
    );

    assign count_ext = QUO_W'(count_reg);
    assign want_eq   = want == count_ext;
    assign cnt_full  = count_reg == CW'(NUM_FRAMES);
    assign scan_exh  = scan_reg == CW'(NUM_FRAMES);
    assign count_dec = count_reg - CW'(1);

    // grow: frame bitmap read is registered; the take decision follows in the next cycle
    assign grow_take = cmd.grow_run && rd_pend_reg && !map_rdata_reg && !want_eq && !cnt_full;
    // shrink: table read issued, frame freed the next cycle
    assign shr_issue = cmd.shr_run && !want_eq;

    assign tbl_waddr = base_reg + TAW'(count_reg);
    assign tbl_raddr = base_reg + TAW'(count_dec);

    always_comb begin
        count_next    = count_reg;
        scan_next     = scan_reg;
        rd_pend_next  = rd_pend_reg;
        shr_pend_next = shr_pend_reg;
        if (cmd.accept) begin
            shr_pend_next = 1'b0;
        end
        if (cmd.cnt_load) begin
            count_next = pc_rdata_reg;
        end
        if (cmd.grow_start) begin
            scan_next    = '0;
            rd_pend_next = 1'b0;
        end
        if (cmd.grow_run) begin
            rd_pend_next = !scan_exh;
            if (!scan_exh) begin
                scan_next = scan_reg + CW'(1);
            end
            if (grow_take) begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.shr_run) begin
            shr_pend_next = shr_issue;
            if (shr_issue) begin
                count_next = count_dec;
            end
        end
    end

    always_comb begin
        map_we    = 1'b0;
        map_waddr = rd_addr_reg;
        map_wdata = 1'b0;
        if (cmd.clr_run && (clr_reg < CLW'(NUM_FRAMES))) begin
            map_we    = 1'b1;
            map_waddr = clr_reg[FW-1:0];
        end else if (grow_take) begin
            map_we    = 1'b1;
            map_wdata = 1'b1;
        end else if (cmd.shr_run && shr_pend_reg && (int'(tbl_rdata_reg) < NUM_FRAMES)) begin
            map_we    = 1'b1;
            map_waddr = tbl_rdata_reg;
        end
    end

    always_comb begin
        pc_we    = 1'b0;
        pc_waddr = proc_reg;
        pc_wdata = count_reg;
        if (cmd.clr_run && (clr_reg < CLW'(NUM_PROCS))) begin
            pc_we    = 1'b1;
            pc_waddr = clr_reg[PIW-1:0];
            pc_wdata = '0;
        end else if (cmd.pc_wr) begin
            pc_we = 1'b1;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[scan_reg[FW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pc_we) begin
            pc_mem[pc_waddr] <= pc_wdata;
        end
        pc_rdata_reg <= pc_mem[pidx_in];
    end

    always_ff @(posedge aclk) begin
        if (grow_take) begin
            tbl_mem[tbl_waddr] <= rd_addr_reg;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pg_size_reg  <= PS_RESET;
            clr_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            shr_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                pg_size_reg <= cfg_wdata;
            end
            if (cmd.clr_run) begin
                clr_reg <= clr_reg + CLW'(1);
            end
            rd_pend_reg  <= rd_pend_next;
            shr_pend_reg <= shr_pend_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        scan_reg  <= scan_next;
        if (cmd.grow_run) begin
            rd_addr_reg <= scan_reg[FW-1:0];
        end
        if (cmd.accept) begin
            proc_reg     <= pidx_in;
            in_range_reg <= int'(proc_ext) < NUM_PROCS;
            size_reg     <= req_size;
        end
        if (cmd.cnt_load) begin
            base_reg <= TAW'(int'(proc_reg) * NUM_FRAMES);
        end
        if (cmd.out_load) begin
            status_reg <= in_range_reg && !want_eq;
        end
    end

    assign sts.clr_done  = clr_reg == CLW'(CLRN);
    assign sts.in_range  = in_range_reg;
    assign sts.div_done  = div_done;
    assign sts.want_gt   = want > count_ext;
    assign sts.want_lt   = want < count_ext;
    assign sts.grow_done = want_eq || (scan_exh && !rd_pend_reg);
    assign sts.shr_done  = want_eq && !shr_pend_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign status   = status_reg;

endmodule

// ----- hdl/pfra_ctrl.sv -----
module pfra_ctrl
    import pfra_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pfra_sts_t sts,
    output pfra_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOAD   = 8'b0000_0100,
        ST_DIV    = 8'b0000_1000,
        ST_GROW   = 8'b0001_0000,
        ST_SHRINK = 8'b0010_0000,
        ST_WB     = 8'b0100_0000,
        ST_RESP   = 8'b1000_0000
    } pfra_state_t;

    pfra_state_t state_reg;
    pfra_state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.clr_run = 1'b1;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (sts.in_range) begin
                    cmd.cnt_load  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    if (sts.want_gt) begin
                        cmd.grow_start = 1'b1;
                        state_next     = ST_GROW;
                    end else if (sts.want_lt) begin
                        state_next = ST_SHRINK;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_GROW: begin
                if (sts.grow_done) begin
                    state_next = ST_WB;
                end else begin
                    cmd.grow_run = 1'b1;
                end
            end
            ST_SHRINK: begin
                if (sts.shr_done) begin
                    state_next = ST_WB;
                end else begin
                    cmd.shr_run = 1'b1;
                end
            end
            ST_WB: begin
                cmd.pc_wr  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/process_frame_resize_allocator.sv -----
// Sequence to m_tvalid: load, divide (33 quotient bits, then done), work, write-back, result;
//   work: grow scan or shrink, both skipped with write-back when the count is unchanged.
// Flow: one transaction at a time, a grow's length set by the scan; an out-of-range id
//   skips to the result; the next request is taken while the result waits at m_tdata.
// Reset: aresetn synchronous, active low; page size back to 4096, then a clearing pass with
//   s_tready low frees all frames and zeroes all page counts.
module process_frame_resize_allocator
    import pfra_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int NUM_PROCS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // page size register write, no read-back
    input  logic                 cfg_we,
    input  logic [PS_W-1:0]      cfg_wdata,

    // request transactions
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] process_id, [35:4] req_size, rest zero

    // result transactions
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] status, rest zero
);

    pfra_cmd_t cmd;
    pfra_sts_t sts;
    logic      status;

    // The controller sequences clear, divide, scan/shrink and write-back;
    // all storage (bitmap, page counts, page tables) lives in the datapath.
    pfra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfra_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .NUM_PROCS  (NUM_PROCS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .proc_id   (s_tdata[PID_LSB +: PID_W]),
        .req_size  (s_tdata[SIZE_LSB +: SIZE_W]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .status    (status),
        .cmd       (cmd),
        .sts       (sts)
    );

    // status: 0 done (also for an out-of-range process id), 1 ran out of free frames (frames already taken are kept)
    assign m_tdata = {{(M_TDATA_W - 1){1'b0}}, status};

endmodule
